// ----- hw/rtl/gradient_noise_3d_assert.svh -----
// ----------------------------------------------------------------------------
// Gradient noise 3D assertion macros
// Shared concurrent assertion forms for the noise pipeline.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_3D_ASSERT_SVH
`define GRADIENT_NOISE_3D_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define GN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define GN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/gn3d_pkg.sv -----
// ----------------------------------------------------------------------------
// Gradient noise 3D package
// Permutation table, widths and helper functions for the noise pipeline.
// ----------------------------------------------------------------------------
package gn3d_pkg;

    localparam int COORD_W = 24;
    localparam int OUT_W   = 18;
    localparam int HASH_W  = 8;

    // Standard permutation of 0..255.
    localparam logic [7:0] PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    // Gradient selector codes, taken from the low four hash bits.
    localparam logic [3:0] H_XV_ZX0 = 4'd12;
    localparam logic [3:0] H_XV_ZX1 = 4'd14;

    function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
        perm_lookup = PERM[idx];
    endfunction

    // Edge gradient dot product; the sum of two signed offsets needs one more bit.
    // Offsets are sized for up to 24 fraction bits.
    function automatic logic signed [26:0] grad_dot(
        input logic [7:0] hash,
        input logic signed [25:0] x,
        input logic signed [25:0] y,
        input logic signed [25:0] z
    );
        logic [3:0] h;
        logic signed [26:0] u;
        logic signed [26:0] v;
        h = hash[3:0];
        u = (h < 4'd8) ? 27'(x) : 27'(y);
        if (h < 4'd4) begin
            v = 27'(y);
        end else if (h == H_XV_ZX0 || h == H_XV_ZX1) begin
            v = 27'(x);
        end else begin
            v = 27'(z);
        end
        grad_dot = (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

// ----- hw/rtl/gn3d_fade.sv -----
// ----------------------------------------------------------------------------
// Gradient noise 3D fade pipeline
// Quintic fade 6t^5 - 15t^4 + 10t^3 over three register stages.
// ----------------------------------------------------------------------------
module gn3d_fade
    import gn3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS-1:0] i_t,
    output logic [FRAC_BITS:0]   o_fade
);

    localparam int FW = FRAC_BITS;
    localparam logic signed [FW+5:0] ONE15 = (FW+6)'(15) <<< FW;
    localparam logic signed [FW+5:0] ONE10 = (FW+6)'(10) <<< FW;

    logic [FW-1:0]          r_t1;
    logic [FW-1:0]          r_sq;
    logic [FW-1:0]          r_cube;
    logic signed [FW+5:0]   r_c;
    logic signed [FW+5:0]   n_c;
    logic signed [FW+5:0]   r_lin;
    logic [2*FW-1:0]        w_sq;
    logic [2*FW-1:0]        w_cube;
    logic signed [2*FW+6:0] w_cp;
    logic signed [2*FW+7:0] w_f;

    assign w_sq   = (2*FW)'(i_t) * (2*FW)'(i_t);
    assign w_cube = (2*FW)'(r_sq) * (2*FW)'(r_t1);
    assign w_cp   = (2*FW+7)'($signed({1'b0, r_t1})) * (2*FW+7)'(r_lin);

    // Stage 1: square and the linear term 6t - 15.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1  <= i_t;
            r_sq  <= w_sq[2*FW-1:FW];
            r_lin <= (FW+6)'($signed({1'b0, i_t})) * (FW+6)'(6) - ONE15;
        end
    end

    // Stage 2: cube and the quadratic c = t(6t - 15) + 10.
    assign n_c = (FW+6)'(w_cp >>> FW) + ONE10;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cube <= w_cube[2*FW-1:FW];
            r_c    <= n_c;
        end
    end

    // Stage 3: fade = t^3 * c, always within [0, ONE].
    assign w_f = (2*FW+8)'($signed({1'b0, r_cube})) * (2*FW+8)'(r_c);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_fade <= (FW+1)'(w_f >>> FW);
        end
    end

endmodule

// ----- hw/rtl/gn3d_lerp.sv -----
// ----------------------------------------------------------------------------
// Gradient noise 3D interpolation stage
// One registered lerp a + floor(t * (b - a) / ONE).
// ----------------------------------------------------------------------------
module gn3d_lerp
    import gn3d_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int VAL_W     = 26
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [FRAC_BITS:0]      i_t,
    input  logic signed [VAL_W-1:0] i_a,
    input  logic signed [VAL_W-1:0] i_b,
    output logic signed [VAL_W-1:0] o_y
);

    localparam int PW = VAL_W + FRAC_BITS + 3;

    logic signed [VAL_W:0] w_d;
    logic signed [PW-1:0]  w_p;

    // The result stays between a and b, so VAL_W bits hold it.
    assign w_d = (VAL_W+1)'(i_b) - (VAL_W+1)'(i_a);
    assign w_p = PW'($signed({1'b0, i_t})) * PW'(w_d);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_y <= i_a + VAL_W'(w_p >>> FRAC_BITS);
        end
    end

endmodule

// ----- hw/rtl/gradient_noise_3d.sv -----
// ----------------------------------------------------------------------------
// Gradient noise 3D
// Improved Perlin gradient noise, one point in and one value out per cycle when not stalled.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata fields (low bit up)
// s_axis   in   x_coord[23:0], y_coord[23:0], z_coord[23:0]
// m_axis   out  noise_value[17:0], zero padded to 24 bits
//
// A new point enters every cycle while the output is not stalled.
// The pipeline stages are three levels of table lookups in the hash chain, the
// gradient stage, three levels of interpolation and the saturating output
// register, each one register stage; the fade runs beside the hash chain.
// The whole pipeline advances only when the output register is free or taken.
// A stall holds every stage; reset clears only the valid bits.
// ----------------------------------------------------------------------------
module gradient_noise_3d
    import gn3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // x_coord, y_coord, z_coord
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // noise_value, zeros
);

    localparam int FW  = FRAC_BITS;
    localparam int OW  = 26;
    localparam int VW  = 27;
    localparam int NST = 8;

    logic [NST-1:0] r_vld;
    logic           w_en;

    logic [FW-1:0] w_fx, w_fy, w_fz;
    logic [7:0]    w_ix, w_iy, w_iz;

    assign w_fx = s_axis_tdata[FW-1:0];
    assign w_fy = s_axis_tdata[24+FW-1:24];
    assign w_fz = s_axis_tdata[48+FW-1:48];
    assign w_ix = 8'(s_axis_tdata[23:0] >> FW);
    assign w_iy = 8'(s_axis_tdata[47:24] >> FW);
    assign w_iz = 8'(s_axis_tdata[71:48] >> FW);

    // Pipeline advances when the last stage is empty or its transaction completes.
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // Fractions delayed along the hash chain (stages 1..3).
    logic [FW-1:0] r_fx [3];
    logic [FW-1:0] r_fy [3];
    logic [FW-1:0] r_fz [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fx[0] <= w_fx;
            r_fy[0] <= w_fy;
            r_fz[0] <= w_fz;
            for (int i = 1; i < 3; i++) begin
                r_fx[i] <= r_fx[i-1];
                r_fy[i] <= r_fy[i-1];
                r_fz[i] <= r_fz[i-1];
            end
        end
    end

    // Hash stage 1: first level lookups.
    logic [7:0] r_pa, r_pb, r_iy1, r_iz1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa  <= perm_lookup(w_ix);
            r_pb  <= perm_lookup(w_ix + 8'd1);
            r_iy1 <= w_iy;
            r_iz1 <= w_iz;
        end
    end

    // Hash stage 2: second level lookups give aa, ab, ba, bb.
    logic [7:0] w_a, w_b;
    logic [7:0] r_aa, r_ab, r_ba, r_bb;
    assign w_a = r_pa + r_iy1;
    assign w_b = r_pb + r_iy1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_aa  <= perm_lookup(w_a) + r_iz1;
            r_ab  <= perm_lookup(w_a + 8'd1) + r_iz1;
            r_ba  <= perm_lookup(w_b) + r_iz1;
            r_bb  <= perm_lookup(w_b + 8'd1) + r_iz1;
        end
    end

    // Hash stage 3: corner hashes, in the order aa, ba, ab, bb for each z.
    logic [7:0] r_h [8];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h[0] <= perm_lookup(r_aa);
            r_h[1] <= perm_lookup(r_ba);
            r_h[2] <= perm_lookup(r_ab);
            r_h[3] <= perm_lookup(r_bb);
            r_h[4] <= perm_lookup(r_aa + 8'd1);
            r_h[5] <= perm_lookup(r_ba + 8'd1);
            r_h[6] <= perm_lookup(r_ab + 8'd1);
            r_h[7] <= perm_lookup(r_bb + 8'd1);
        end
    end

    // Stage 4: gradient dot products at the eight corners.
    logic signed [OW-1:0] w_px, w_py, w_pz, w_qx, w_qy, w_qz;
    logic signed [VW-1:0] r_g [8];
    assign w_px = OW'($signed({1'b0, r_fx[2]}));
    assign w_py = OW'($signed({1'b0, r_fy[2]}));
    assign w_pz = OW'($signed({1'b0, r_fz[2]}));
    assign w_qx = w_px - (OW'(1) <<< FW);
    assign w_qy = w_py - (OW'(1) <<< FW);
    assign w_qz = w_pz - (OW'(1) <<< FW);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 8; c++) begin
                r_g[c] <= grad_dot(r_h[c],
                                   c[0] ? w_qx : w_px,
                                   c[1] ? w_qy : w_py,
                                   c[2] ? w_qz : w_pz);
            end
        end
    end

    // Fade units; outputs line up with stage 3, then are delayed to match lerps.
    logic [FW:0] w_u, w_v, w_w;
    gn3d_fade #(.FRAC_BITS(FW)) u_fade_x (.i_clk(i_clk), .i_en(w_en), .i_t(w_fx), .o_fade(w_u));
    gn3d_fade #(.FRAC_BITS(FW)) u_fade_y (.i_clk(i_clk), .i_en(w_en), .i_t(w_fy), .o_fade(w_v));
    gn3d_fade #(.FRAC_BITS(FW)) u_fade_z (.i_clk(i_clk), .i_en(w_en), .i_t(w_fz), .o_fade(w_w));

    logic [FW:0] r_u4, r_v4, r_v5, r_w4, r_w5, r_w6;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u4 <= w_u;
            r_v4 <= w_v;
            r_v5 <= r_v4;
            r_w4 <= w_w;
            r_w5 <= r_w4;
            r_w6 <= r_w5;
        end
    end

    // Stage 5: four lerps along x.
    logic signed [VW-1:0] w_l1 [4];
    for (genvar k = 0; k < 4; k++) begin : g_lx
        gn3d_lerp #(.FRAC_BITS(FW), .VAL_W(VW)) u_lerp (
            .i_clk(i_clk), .i_en(w_en), .i_t(r_u4),
            .i_a(r_g[2*k]), .i_b(r_g[2*k+1]), .o_y(w_l1[k]));
    end

    // Stage 6: two lerps along y.
    logic signed [VW-1:0] w_l2 [2];
    for (genvar k = 0; k < 2; k++) begin : g_ly
        gn3d_lerp #(.FRAC_BITS(FW), .VAL_W(VW)) u_lerp (
            .i_clk(i_clk), .i_en(w_en), .i_t(r_v5),
            .i_a(w_l1[2*k]), .i_b(w_l1[2*k+1]), .o_y(w_l2[k]));
    end

    // Stage 7: final lerp along z.
    logic signed [VW-1:0] w_r;
    gn3d_lerp #(.FRAC_BITS(FW), .VAL_W(VW)) u_lerp_z (
        .i_clk(i_clk), .i_en(w_en), .i_t(r_w6),
        .i_a(w_l2[0]), .i_b(w_l2[1]), .o_y(w_r));

    // Stage 8: saturate into the output register.
    localparam logic signed [VW-1:0] SAT_HI = VW'(131071);
    localparam logic signed [VW-1:0] SAT_LO = -VW'(131072);
    logic [OUT_W-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_r > SAT_HI) begin
                r_out <= OUT_W'(SAT_HI);
            end else if (w_r < SAT_LO) begin
                r_out <= OUT_W'(SAT_LO);
            end else begin
                r_out <= OUT_W'(w_r);
            end
        end
    end

    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata  = {(24-OUT_W)'(0), r_out};

    // Output transaction offered but not taken.
    logic w_stall;
    assign w_stall = m_axis_tvalid && !m_axis_tready;

`include "gradient_noise_3d_assert.svh"

    `GN_ASSERT_IMPL(a_stall_hold, i_clk, i_rst_n, w_stall, !s_axis_tready)
    `GN_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, w_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `GN_ASSERT_NEXT(a_vld_shift, i_clk, i_rst_n, w_en && r_vld[NST-2], m_axis_tvalid)

endmodule
